// ----- rtl/cau_pkg.sv -----
`timescale 1ns / 1ps

package cau_pkg;

  // Fixed-point format of operands and results.
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned FRAC_BITS  = 16;

  // Products and sums of products carry twice the data width.
  localparam int unsigned PROD_W = 2 * DATA_WIDTH;
  // Integer bits of a quotient that still fits the data width.
  localparam int unsigned LOW_W  = DATA_WIDTH - FRAC_BITS;
  // One quotient bit and one root bit per pipeline step.
  localparam int unsigned NSTEP  = DATA_WIDTH;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic        [PROD_W-1:0]     wide_t;

  localparam data_t MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam data_t MIN_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef enum logic [2:0] {
    ACT_ADD  = 3'd0,
    ACT_SUB  = 3'd1,
    ACT_MUL  = 3'd2,
    ACT_DIV  = 3'd3,
    ACT_MAG  = 3'd4,
    ACT_REAL = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_OVF  = 2'd2
  } status_e;

  // Payload of one request inside the divide and root pipeline.
  typedef struct packed {
    action_e             act;
    data_t               fin_re;
    data_t               fin_im;
    logic                fin_ovf;
    logic                div0;
    logic                neg_re;
    logic                neg_im;
    logic                pre_ovf_re;
    logic                pre_ovf_im;
    wide_t               den;
    wide_t               r_re;
    wide_t               r_im;
    logic [LOW_W-1:0]    lo_re;
    logic [LOW_W-1:0]    lo_im;
    logic [DATA_WIDTH-1:0] q_re;
    logic [DATA_WIDTH-1:0] q_im;
    wide_t               sx;
    wide_t               sres;
  } it_t;

endpackage

// ----- rtl/cau_if.sv -----
`timescale 1ns / 1ps

// Operand request channel.
interface cau_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [2:0]                             action;
  logic signed [cau_pkg::DATA_WIDTH-1:0]  a_re;
  logic signed [cau_pkg::DATA_WIDTH-1:0]  a_im;
  logic signed [cau_pkg::DATA_WIDTH-1:0]  b_re;
  logic signed [cau_pkg::DATA_WIDTH-1:0]  b_im;

  modport source (output valid, action, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, action, a_re, a_im, b_re, b_im, output ready);
endinterface

// Result request channel.
interface cau_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [cau_pkg::DATA_WIDTH-1:0]  res_re;
  logic signed [cau_pkg::DATA_WIDTH-1:0]  res_im;
  logic [1:0]                             status;

  modport source (output valid, res_re, res_im, status, input ready);
  modport sink   (input valid, res_re, res_im, status, output ready);
endinterface

// ----- rtl/cau_iter.sv -----
`timescale 1ns / 1ps

// Pipelined restoring divider for both quotient lanes and a restoring
// square root, one quotient bit and one root bit per stage.
module cau_iter (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  cau_pkg::it_t  data_i,
  output logic          valid_o,
  output cau_pkg::it_t  data_o
);

  cau_pkg::it_t            st_q [cau_pkg::NSTEP+1];
  cau_pkg::it_t            st_d [cau_pkg::NSTEP];
  logic [cau_pkg::NSTEP:0] v_q;

  // One division step on each lane and one root step.
  function automatic cau_pkg::it_t step(cau_pkg::it_t s, int unsigned k);
    cau_pkg::it_t          o;
    logic [cau_pkg::PROD_W:0] r2;
    logic [cau_pkg::PROD_W:0] dd;
    cau_pkg::wide_t        b;
    cau_pkg::wide_t        t;
    o  = s;
    dd = {1'b0, s.den};

    r2 = {s.r_re, s.lo_re[cau_pkg::LOW_W-1]};
    if (r2 >= dd) begin
      r2 = r2 - dd;
      o.q_re = {s.q_re[cau_pkg::DATA_WIDTH-2:0], 1'b1};
    end else begin
      o.q_re = {s.q_re[cau_pkg::DATA_WIDTH-2:0], 1'b0};
    end
    o.r_re  = r2[cau_pkg::PROD_W-1:0];
    o.lo_re = s.lo_re << 1;

    r2 = {s.r_im, s.lo_im[cau_pkg::LOW_W-1]};
    if (r2 >= dd) begin
      r2 = r2 - dd;
      o.q_im = {s.q_im[cau_pkg::DATA_WIDTH-2:0], 1'b1};
    end else begin
      o.q_im = {s.q_im[cau_pkg::DATA_WIDTH-2:0], 1'b0};
    end
    o.r_im  = r2[cau_pkg::PROD_W-1:0];
    o.lo_im = s.lo_im << 1;

    // Root bit weight falls by a factor of four per stage.
    b = cau_pkg::wide_t'(1) << (cau_pkg::PROD_W - 2 - 2 * k);
    t = s.sres + b;
    if (s.sx >= t) begin
      o.sx   = s.sx - t;
      o.sres = (s.sres >> 1) + b;
    end else begin
      o.sres = s.sres >> 1;
    end
    return o;
  endfunction

  // Next contents of each step stage.
  always_comb begin
    for (int unsigned k = 0; k < cau_pkg::NSTEP; k++) begin
      st_d[k] = step(st_q[k], k);
    end
  end

  // Valid bits move with the data under the shared enable.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[cau_pkg::NSTEP-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= data_i;
      for (int unsigned k = 0; k < cau_pkg::NSTEP; k++) begin
        st_q[k+1] <= st_d[k];
      end
    end
  end

  assign valid_o = v_q[cau_pkg::NSTEP];
  assign data_o  = st_q[cau_pkg::NSTEP];

endmodule

// ----- rtl/complex_arith_unit_top.sv -----
`timescale 1ns / 1ps

// Complex arithmetic unit in signed Q16.16: add, subtract, multiply, divide,
// magnitude and real-to-complex, with saturation and a status code per result.
// The block accepts one request every cycle unless stalled and delivers
// results in order through four front stages (input, multipliers, sums of
// products, absolute values), one stage of divide and overflow setup, and
// 32 stages of the shared divide and square-root pipeline, each producing one
// quotient bit per lane and one root bit. A two-entry output queue holds
// finished results; the input stalls only while both entries are occupied.
module complex_arith_unit_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  cau_in_if.sink      in_i,
  cau_out_if.source   out_o
);

  localparam int unsigned DW = cau_pkg::DATA_WIDTH;
  localparam int unsigned PW = cau_pkg::PROD_W;

  typedef struct packed {
    logic          ovf;
    cau_pkg::data_t val;
  } lane_t;

  typedef struct packed {
    cau_pkg::action_e act;
    cau_pkg::data_t   a_re;
    cau_pkg::data_t   a_im;
    cau_pkg::data_t   b_re;
    cau_pkg::data_t   b_im;
    cau_pkg::data_t   m_br;
    cau_pkg::data_t   m_bi;
    lane_t            s_re;
    lane_t            s_im;
  } s1_t;

  typedef struct packed {
    cau_pkg::action_e   act;
    lane_t              s_re;
    lane_t              s_im;
    logic signed [PW-1:0] p_rr;
    logic signed [PW-1:0] p_ii;
    logic signed [PW-1:0] p_ri;
    logic signed [PW-1:0] p_ir;
    logic signed [PW-1:0] p_dr;
    logic signed [PW-1:0] p_di;
  } s2_t;

  typedef struct packed {
    cau_pkg::action_e act;
    lane_t            s_re;
    lane_t            s_im;
    logic signed [PW:0] mre;
    logic signed [PW:0] mim;
    logic signed [PW:0] dre;
    logic signed [PW:0] dim;
    cau_pkg::wide_t   den;
  } s3_t;

  typedef struct packed {
    cau_pkg::action_e act;
    lane_t            s_re;
    lane_t            s_im;
    logic             mre_neg;
    logic             mim_neg;
    logic             dre_neg;
    logic             dim_neg;
    cau_pkg::wide_t   mre_mag;
    cau_pkg::wide_t   mim_mag;
    cau_pkg::wide_t   dre_mag;
    cau_pkg::wide_t   dim_mag;
    cau_pkg::wide_t   den;
  } s4_t;

  typedef struct packed {
    cau_pkg::data_t   res_re;
    cau_pkg::data_t   res_im;
    cau_pkg::status_e status;
  } res_t;

  localparam cau_pkg::wide_t LIM_POS = {{(PW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam cau_pkg::wide_t LIM_NEG = LIM_POS + cau_pkg::wide_t'(1);

  // Saturate a sum that is one bit wider than the data.
  function automatic lane_t sat_sum(logic signed [DW:0] s);
    lane_t l;
    l.ovf = s[DW] ^ s[DW-1];
    if (l.ovf) begin
      l.val = s[DW] ? cau_pkg::MIN_NEG : cau_pkg::MAX_POS;
    end else begin
      l.val = s[DW-1:0];
    end
    return l;
  endfunction

  // Drop the fraction bits of a product magnitude and saturate.
  function automatic lane_t mul_fix(logic neg, cau_pkg::wide_t mag);
    lane_t          l;
    cau_pkg::wide_t sh;
    sh    = mag >> cau_pkg::FRAC_BITS;
    l.ovf = 1'b0;
    if (!neg && sh > LIM_POS) begin
      l.ovf = 1'b1;
      l.val = cau_pkg::MAX_POS;
    end else if (neg && sh > LIM_NEG) begin
      l.ovf = 1'b1;
      l.val = cau_pkg::MIN_NEG;
    end else begin
      l.val = neg ? -sh[DW-1:0] : sh[DW-1:0];
    end
    return l;
  endfunction

  // Apply sign and saturation to a finished quotient.
  function automatic lane_t div_fix(logic neg, logic pre, logic [DW-1:0] q);
    lane_t l;
    l.ovf = 1'b0;
    if (pre || (!neg && q[DW-1]) || (neg && q[DW-1] && (|q[DW-2:0]))) begin
      l.ovf = 1'b1;
      l.val = neg ? cau_pkg::MIN_NEG : cau_pkg::MAX_POS;
    end else begin
      l.val = neg ? -q : q;
    end
    return l;
  endfunction

  logic         en;
  logic [1:0]   cnt_q;
  s1_t          s1_d, s1_q;
  s2_t          s2_d, s2_q;
  s3_t          s3_d, s3_q;
  s4_t          s4_d, s4_q;
  logic [3:0]   v_q;
  cau_pkg::it_t it_in;
  cau_pkg::it_t it_out;
  logic         it_v;
  res_t         fin;

  // The pipeline advances while the output queue has a free entry.
  assign en         = (cnt_q != 2'd2);
  assign in_i.ready = en;

  // Input stage: operand selection, add and subtract.
  always_comb begin
    cau_pkg::action_e act;
    logic signed [DW:0] sr;
    logic signed [DW:0] si;
    sr        = '0;
    si        = '0;
    act       = cau_pkg::action_e'(in_i.action);
    s1_d.act  = act;
    s1_d.a_re = in_i.a_re;
    s1_d.a_im = in_i.a_im;
    s1_d.b_re = in_i.b_re;
    s1_d.b_im = in_i.b_im;
    // The magnitude reuses the real divide numerator sum as a_re^2 + a_im^2.
    s1_d.m_br = (act == cau_pkg::ACT_MAG) ? in_i.a_re : in_i.b_re;
    s1_d.m_bi = (act == cau_pkg::ACT_MAG) ? in_i.a_im : in_i.b_im;
    s1_d.s_re = '0;
    s1_d.s_im = '0;
    case (act)
      cau_pkg::ACT_ADD: begin
        sr = {in_i.a_re[DW-1], in_i.a_re} + {in_i.b_re[DW-1], in_i.b_re};
        si = {in_i.a_im[DW-1], in_i.a_im} + {in_i.b_im[DW-1], in_i.b_im};
        s1_d.s_re = sat_sum(sr);
        s1_d.s_im = sat_sum(si);
      end
      cau_pkg::ACT_SUB: begin
        sr = {in_i.a_re[DW-1], in_i.a_re} - {in_i.b_re[DW-1], in_i.b_re};
        si = {in_i.a_im[DW-1], in_i.a_im} - {in_i.b_im[DW-1], in_i.b_im};
        s1_d.s_re = sat_sum(sr);
        s1_d.s_im = sat_sum(si);
      end
      cau_pkg::ACT_REAL: begin
        s1_d.s_re.val = in_i.a_re;
      end
      default: begin
        s1_d.s_re = '0;
      end
    endcase
  end

  // Multiplier stage.
  always_comb begin
    s2_d.act  = s1_q.act;
    s2_d.s_re = s1_q.s_re;
    s2_d.s_im = s1_q.s_im;
    s2_d.p_rr = s1_q.a_re * s1_q.m_br;
    s2_d.p_ii = s1_q.a_im * s1_q.m_bi;
    s2_d.p_ri = s1_q.a_re * s1_q.b_im;
    s2_d.p_ir = s1_q.a_im * s1_q.b_re;
    s2_d.p_dr = s1_q.b_re * s1_q.b_re;
    s2_d.p_di = s1_q.b_im * s1_q.b_im;
  end

  // Sums of products for multiply, divide and magnitude.
  always_comb begin
    s3_d.act  = s2_q.act;
    s3_d.s_re = s2_q.s_re;
    s3_d.s_im = s2_q.s_im;
    s3_d.mre  = {s2_q.p_rr[PW-1], s2_q.p_rr} - {s2_q.p_ii[PW-1], s2_q.p_ii};
    s3_d.mim  = {s2_q.p_ri[PW-1], s2_q.p_ri} + {s2_q.p_ir[PW-1], s2_q.p_ir};
    s3_d.dre  = {s2_q.p_rr[PW-1], s2_q.p_rr} + {s2_q.p_ii[PW-1], s2_q.p_ii};
    s3_d.dim  = {s2_q.p_ir[PW-1], s2_q.p_ir} - {s2_q.p_ri[PW-1], s2_q.p_ri};
    s3_d.den  = s2_q.p_dr + s2_q.p_di;
  end

  // Sign and magnitude of each sum.
  always_comb begin
    logic [PW:0] t;
    s4_d.act     = s3_q.act;
    s4_d.s_re    = s3_q.s_re;
    s4_d.s_im    = s3_q.s_im;
    s4_d.den     = s3_q.den;
    s4_d.mre_neg = s3_q.mre[PW];
    t            = s3_q.mre[PW] ? -s3_q.mre : s3_q.mre;
    s4_d.mre_mag = t[PW-1:0];
    s4_d.mim_neg = s3_q.mim[PW];
    t            = s3_q.mim[PW] ? -s3_q.mim : s3_q.mim;
    s4_d.mim_mag = t[PW-1:0];
    s4_d.dre_neg = s3_q.dre[PW];
    t            = s3_q.dre[PW] ? -s3_q.dre : s3_q.dre;
    s4_d.dre_mag = t[PW-1:0];
    s4_d.dim_neg = s3_q.dim[PW];
    t            = s3_q.dim[PW] ? -s3_q.dim : s3_q.dim;
    s4_d.dim_mag = t[PW-1:0];
  end

  // Setup of the divide and root pipeline, and the finished multiply.
  always_comb begin
    lane_t lre;
    lane_t lim;
    lre               = mul_fix(s4_q.mre_neg, s4_q.mre_mag);
    lim               = mul_fix(s4_q.mim_neg, s4_q.mim_mag);
    it_in             = '0;
    it_in.act         = s4_q.act;
    case (s4_q.act)
      cau_pkg::ACT_ADD, cau_pkg::ACT_SUB, cau_pkg::ACT_REAL: begin
        it_in.fin_re  = s4_q.s_re.val;
        it_in.fin_im  = s4_q.s_im.val;
        it_in.fin_ovf = s4_q.s_re.ovf | s4_q.s_im.ovf;
      end
      cau_pkg::ACT_MUL: begin
        it_in.fin_re  = lre.val;
        it_in.fin_im  = lim.val;
        it_in.fin_ovf = lre.ovf | lim.ovf;
      end
      default: begin
        it_in.fin_ovf = 1'b0;
      end
    endcase
    it_in.div0       = (s4_q.den == '0);
    it_in.den        = s4_q.den;
    it_in.neg_re     = s4_q.dre_neg;
    it_in.neg_im     = s4_q.dim_neg;
    // A quotient of 2^DW or more shows as numerator >= denominator shifted.
    it_in.pre_ovf_re = {{cau_pkg::LOW_W{1'b0}}, s4_q.dre_mag}
                       >= {s4_q.den, {cau_pkg::LOW_W{1'b0}}};
    it_in.pre_ovf_im = {{cau_pkg::LOW_W{1'b0}}, s4_q.dim_mag}
                       >= {s4_q.den, {cau_pkg::LOW_W{1'b0}}};
    it_in.r_re       = s4_q.dre_mag >> cau_pkg::LOW_W;
    it_in.r_im       = s4_q.dim_mag >> cau_pkg::LOW_W;
    it_in.lo_re      = s4_q.dre_mag[cau_pkg::LOW_W-1:0];
    it_in.lo_im      = s4_q.dim_mag[cau_pkg::LOW_W-1:0];
    it_in.sx         = s4_q.dre_mag;
  end

  // Front stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
    end
  end

  cau_iter u_iter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_q[3]),
    .data_i  (it_in),
    .valid_o (it_v),
    .data_o  (it_out)
  );

  // Result selection and status.
  always_comb begin
    lane_t lre;
    lane_t lim;
    lre        = div_fix(it_out.neg_re, it_out.pre_ovf_re, it_out.q_re);
    lim        = div_fix(it_out.neg_im, it_out.pre_ovf_im, it_out.q_im);
    fin.res_re = it_out.fin_re;
    fin.res_im = it_out.fin_im;
    fin.status = it_out.fin_ovf ? cau_pkg::ST_OVF : cau_pkg::ST_OK;
    case (it_out.act)
      cau_pkg::ACT_DIV: begin
        if (it_out.div0) begin
          fin.res_re = '0;
          fin.res_im = '0;
          fin.status = cau_pkg::ST_DIV0;
        end else begin
          fin.res_re = lre.val;
          fin.res_im = lim.val;
          fin.status = (lre.ovf | lim.ovf) ? cau_pkg::ST_OVF : cau_pkg::ST_OK;
        end
      end
      cau_pkg::ACT_MAG: begin
        fin.res_im = '0;
        if (|it_out.sres[PW-1:DW-1]) begin
          fin.res_re = cau_pkg::MAX_POS;
          fin.status = cau_pkg::ST_OVF;
        end else begin
          fin.res_re = it_out.sres[DW-1:0];
          fin.status = cau_pkg::ST_OK;
        end
      end
      default: begin
        fin.res_re = it_out.fin_re;
      end
    endcase
  end

  // Two-entry output queue.
  res_t q_mem [2];
  logic wr_ptr_q;
  logic rd_ptr_q;
  logic push;
  logic pop;

  assign push = en && it_v;
  assign pop  = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= fin;
    end
  end

  assign out_o.valid  = (cnt_q != 2'd0);
  assign out_o.res_re = q_mem[rd_ptr_q].res_re;
  assign out_o.res_im = q_mem[rd_ptr_q].res_im;
  assign out_o.status = q_mem[rd_ptr_q].status;

endmodule

// ----- bench/cau_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels, computes the expected result of each accepted request
// and compares it with what the block delivers, in order.
module cau_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  cau_in_if           in_mon,
  cau_out_if          out_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned done_count_o
);

  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    logic [1:0]  st;
  } cplx_res_t;

  cplx_res_t result_fifo[$];
  int unsigned fails;
  int unsigned done_cnt;

  assign fail_count_o = fails;
  assign pending_o    = result_fifo.size();
  assign done_count_o = done_cnt;

  // Clamp a signed value to the data range, flagging overflow.
  function automatic logic [31:0] clamp(input logic signed [127:0] v, inout logic ovf);
    if (v > 128'sh7fffffff) begin
      ovf = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -128'sh80000000) begin
      ovf = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  // Quotient of num/den truncated toward zero, with FRAC_BITS fraction bits.
  function automatic logic [31:0] fix_div(input logic signed [127:0] num,
                                          input logic [127:0] den, inout logic ovf);
    logic          neg;
    logic [127:0]  mag;
    logic [127:0]  q;
    neg = num < 0;
    mag = neg ? -num : num;
    q = mag / den;
    if (q > (128'd1 << (31 - cau_pkg::FRAC_BITS))) begin
      ovf = 1'b1;
      return neg ? 32'h80000000 : 32'h7fffffff;
    end
    q = (mag << cau_pkg::FRAC_BITS) / den;
    return clamp(neg ? -$signed(q) : $signed(q), ovf);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [127:0] x);
    logic [127:0] r;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      if ((r | (128'd1 << b)) * (r | (128'd1 << b)) <= x) r = r | (128'd1 << b);
    end
    return r[63:0];
  endfunction

  // Arithmetic of one request, exact in 128 bits before rescaling.
  function automatic cplx_res_t compute_result(input logic [2:0] act,
      input logic signed [31:0] ar, ai, br, bi);
    cplx_res_t r;
    logic ovf;
    logic signed [127:0] xr, xi, yr, yi, t;
    logic [127:0] den;
    ovf = 1'b0;
    r.re = '0; r.im = '0; r.st = cau_pkg::ST_OK;
    xr = ar; xi = ai; yr = br; yi = bi;
    case (act)
      cau_pkg::ACT_ADD: begin
        r.re = clamp(xr + yr, ovf);
        r.im = clamp(xi + yi, ovf);
      end
      cau_pkg::ACT_SUB: begin
        r.re = clamp(xr - yr, ovf);
        r.im = clamp(xi - yi, ovf);
      end
      cau_pkg::ACT_MUL: begin
        // Shift of magnitude truncates toward zero.
        t = xr * yr - xi * yi;
        r.re = clamp(t < 0 ? -((-t) >>> cau_pkg::FRAC_BITS) : t >>> cau_pkg::FRAC_BITS,
                     ovf);
        t = xr * yi + xi * yr;
        r.im = clamp(t < 0 ? -((-t) >>> cau_pkg::FRAC_BITS) : t >>> cau_pkg::FRAC_BITS,
                     ovf);
      end
      cau_pkg::ACT_DIV: begin
        den = yr * yr + yi * yi;
        if (den == 0) r.st = cau_pkg::ST_DIV0;
        else begin
          r.re = fix_div(xr * yr + xi * yi, den, ovf);
          r.im = fix_div(xi * yr - xr * yi, den, ovf);
        end
      end
      cau_pkg::ACT_MAG: r.re = clamp($signed({64'd0, int_sqrt(xr * xr + xi * xi)}), ovf);
      cau_pkg::ACT_REAL: r.re = ar;
      default: ;
    endcase
    if (ovf) r.st = cau_pkg::ST_OVF;
    return r;
  endfunction

  // Predict on each accepted request, compare on each accepted result.
  always @(posedge clk_i or negedge rst_ni) begin
    cplx_res_t e;
    if (!rst_ni) begin
      fails    <= 0;
      done_cnt <= 0;
      result_fifo.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        result_fifo.push_back(compute_result(in_mon.action, in_mon.a_re, in_mon.a_im,
                                             in_mon.b_re, in_mon.b_im));
      if (out_mon.valid && out_mon.ready) begin
        done_cnt <= done_cnt + 1;
        if (result_fifo.size() == 0) begin
          $error("result with nothing expected: re=%h im=%h status=%0d",
                 out_mon.res_re, out_mon.res_im, out_mon.status);
          fails <= fails + 1;
        end else begin
          e = result_fifo.pop_front();
          if (out_mon.res_re !== e.re || out_mon.res_im !== e.im ||
              out_mon.status !== e.st) begin
            if (out_mon.res_re !== e.re)
              $error("res_re expected %h actual %h", e.re, out_mon.res_re);
            if (out_mon.res_im !== e.im)
              $error("res_im expected %h actual %h", e.im, out_mon.res_im);
            if (out_mon.status !== e.st)
              $error("status expected %0d actual %0d", e.st, out_mon.status);
            fails <= fails + 1;
          end
        end
      end
    end
  end

endmodule

// ----- bench/complex_arith_unit_top_tb.sv -----
`timescale 1ns / 1ps

module complex_arith_unit_top_tb;

  localparam int unsigned RANDOM_REQS = 1500;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_WAIT  = 60;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int unsigned fail_count, pending, done_count, cycles, sent;

  cau_in_if  req_ch();
  cau_out_if res_ch();

  always #2 clk_i = ~clk_i;

  complex_arith_unit_top u_dut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(req_ch), .out_o(res_ch));

  cau_checker u_checker (.clk_i(clk_i), .rst_ni(rst_ni), .in_mon(req_ch), .out_mon(res_ch),
    .fail_count_o(fail_count), .pending_o(pending), .done_count_o(done_count));

  // Edge-heavy operand values.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return 32'h00010000;
      4: return 32'hffff0000;
      5: return $urandom_range(0, 32'h1ffff) - 32'h10000;
      6: return $urandom & 32'h00ffffff;
      7: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // Send one request and hold it until it is taken.
  task automatic send_req(input logic [2:0] act, input logic [31:0] ar, ai, br, bi);
    req_ch.valid  <= 1'b1;
    req_ch.action <= act;
    req_ch.a_re   <= ar;
    req_ch.a_im   <= ai;
    req_ch.b_re   <= br;
    req_ch.b_im   <= bi;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    sent++;
  endtask

  task automatic idle_cycles(input int unsigned n);
    req_ch.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Receiver stalls: long open stretches alternating with stall-heavy ones.
  always @(posedge clk_i) begin
    if (cycles % 600 < 200) res_ch.ready <= 1'b1;
    else res_ch.ready <= ($urandom_range(0, 3) != 0) && (cycles % 37 > 4);
  end

  // Cycle limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned burst;
    logic [31:0] m;
    req_ch.valid = 1'b0; req_ch.action = cau_pkg::ACT_ADD;
    req_ch.a_re = '0; req_ch.a_im = '0; req_ch.b_re = '0; req_ch.b_im = '0;
    res_ch.ready = 1'b0;
    sent = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every operation, saturation, divide by zero, unused codes.
    send_req(cau_pkg::ACT_ADD,  32'h7fffffff, 32'h80000000, 32'h1, 32'hffffffff);
    send_req(cau_pkg::ACT_ADD,  32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    send_req(cau_pkg::ACT_SUB,  32'h80000000, 32'h7fffffff, 32'h1, 32'hffffffff);
    send_req(cau_pkg::ACT_SUB,  32'h00010000, 32'h00020000, 32'h00030000, 32'hfffc0000);
    send_req(cau_pkg::ACT_MUL,  32'h00020000, 32'h00030000, 32'h00040000, 32'hfffb0000);
    send_req(cau_pkg::ACT_MUL,  32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    send_req(cau_pkg::ACT_MUL,  32'hffffffff, 32'h0, 32'h1, 32'h0);
    send_req(cau_pkg::ACT_MUL,  32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    send_req(cau_pkg::ACT_DIV,  32'h00010000, 32'h0, 32'h0, 32'h0);
    send_req(cau_pkg::ACT_DIV,  32'h00050000, 32'h00030000, 32'h00010000, 32'h00020000);
    send_req(cau_pkg::ACT_DIV,  32'h7fffffff, 32'h80000000, 32'h1, 32'h0);
    send_req(cau_pkg::ACT_DIV,  32'h80000000, 32'h0, 32'h00010000, 32'h0);
    send_req(cau_pkg::ACT_DIV,  32'h1, 32'hffffffff, 32'h7fffffff, 32'h80000000);
    send_req(cau_pkg::ACT_DIV,  32'h80000000, 32'h0, 32'hffff0000, 32'h0);
    send_req(cau_pkg::ACT_MAG,  32'h00030000, 32'h00040000, 32'h0, 32'h0);
    send_req(cau_pkg::ACT_MAG,  32'h80000000, 32'h80000000, 32'h0, 32'h0);
    send_req(cau_pkg::ACT_MAG,  32'h7fffffff, 32'h0, 32'h0, 32'h0);
    send_req(cau_pkg::ACT_REAL, 32'h80000000, 32'h12345678, 32'h1, 32'h2);
    send_req(cau_pkg::ACT_REAL, 32'h7fffffff, 32'h0, 32'h0, 32'h0);
    send_req(3'd6, 32'h1, 32'h2, 32'h3, 32'h4);
    send_req(3'd7, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);

    // Let everything drain once before random traffic.
    idle_cycles(1);
    while (pending != 0) @(posedge clk_i);

    // Random traffic in bursts separated by random gaps.
    while (sent < RANDOM_REQS + 21) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        m = $urandom_range(0, 15);
        send_req(m < 14 ? 3'(m % 6) : 3'(m - 8), pick_operand(), pick_operand(),
                 pick_operand(), pick_operand());
      end
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 12));
      if (sent > 700 && sent < 741) begin
        idle_cycles(1);
        while (pending != 0) @(posedge clk_i);
      end
    end
    req_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("Sent %0d requests over all six operations and unused codes,", sent);
    $display("with saturation and zero-divisor cases; %0d results checked.", done_count);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
